// ===== src/motor_command_line_parser_assert.svh =====
// assertion macros shared by the parser checks
`ifndef MOTOR_COMMAND_LINE_PARSER_ASSERT_SVH
`define MOTOR_COMMAND_LINE_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk and held off during rst
`define MCLP_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk and held off during rst
`define MCLP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/mclp_pkg.sv =====
// types, codes and constants of the motor command line parser
`timescale 1ns / 1ps

package mclp_pkg;

  localparam logic [3:0] FIELD_CHARS = 4'd15;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_R       = 8'h52;
  localparam logic [7:0] CHAR_T       = 8'h54;
  localparam logic [7:0] CHAR_F       = 8'h46;
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;

  localparam logic [3:0] DIGIT_MOTOR_ONE = 4'd1;
  localparam logic [3:0] DIGIT_MOTOR_TWO = 4'd2;

  localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  typedef enum logic [3:0] {
    TK_NEWLINE,
    TK_DIGIT,
    TK_PLUS,
    TK_MINUS,
    TK_LETTER_A,
    TK_LETTER_R,
    TK_LETTER_T,
    TK_LETTER_F,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
  } token_t;

  typedef enum logic [1:0] {
    STAGE_MOTOR,
    STAGE_CMD,
    STAGE_FIELDS,
    STAGE_IGNORE
  } stage_t;

  typedef enum logic [1:0] {
    KIND_ABS,
    KIND_REL,
    KIND_VEL
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_EMPTY,
    ERR_BAD_MOTOR,
    ERR_NO_CMD,
    ERR_FEEDBACK,
    ERR_UNKNOWN
  } err_code_t;

endpackage

// ===== src/motor_command_line_parser.sv =====
// motor command line parser top level
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid / rx_stall  rx_byte
//   cmd      out        cmd_valid / cmd_stall accepted, error_code, motor_id,
//                                            command_kind, target/speed/accel_value
//
// one byte per cycle unless rx_stall; the parser takes a word from a two-word queue
// every cycle that it holds one, but a newline leaves the queue only when the result
// register is free or being taken, so a stalled result backs the queue up and then
// rx_stall rises; the result appears in the cycle after its newline leaves the queue
// synchronous reset; no clearing pass
`timescale 1ns / 1ps

module motor_command_line_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               cmd_valid,
  input  logic               cmd_stall,
  output logic               accepted,
  output logic [2:0]         error_code,
  output logic               motor_id,
  output logic [1:0]         command_kind,
  output logic signed [31:0] target_value,
  output logic signed [31:0] speed_value,
  output logic signed [31:0] accel_value
);
  import mclp_pkg::*;

  token_t front_tok, queue_tok;
  logic   push, q_full, q_valid, q_pop;

  mclp_front u_front (
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_stall (rx_stall),
    .q_full   (q_full),
    .push     (push),
    .tok      (front_tok)
  );

  mclp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_tok),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (queue_tok),
    .valid (q_valid)
  );

  mclp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .tok          (queue_tok),
    .q_pop        (q_pop),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .accepted     (accepted),
    .error_code   (error_code),
    .motor_id     (motor_id),
    .command_kind (command_kind),
    .target_value (target_value),
    .speed_value  (speed_value),
    .accel_value  (accel_value)
  );

endmodule

// ===== src/mclp_front.sv =====
// front end: takes received bytes and classifies them into tokens
`timescale 1ns / 1ps

module mclp_front (
  input  logic           rx_valid,
  input  logic [7:0]     rx_byte,
  output logic           rx_stall,
  input  logic           q_full,
  output logic           push,
  output mclp_pkg::token_t tok
);
  import mclp_pkg::*;

  assign rx_stall = q_full;
  assign push     = rx_valid && !q_full;

  always_comb begin
    // ascii digits carry their value in the low nibble
    tok.digit = rx_byte[3:0];
    if (rx_byte == CHAR_NEWLINE) begin
      tok.kind = TK_NEWLINE;
    end else if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
      tok.kind = TK_DIGIT;
    end else if (rx_byte == CHAR_PLUS) begin
      tok.kind = TK_PLUS;
    end else if (rx_byte == CHAR_MINUS) begin
      tok.kind = TK_MINUS;
    end else if (rx_byte == CHAR_A) begin
      tok.kind = TK_LETTER_A;
    end else if (rx_byte == CHAR_R) begin
      tok.kind = TK_LETTER_R;
    end else if (rx_byte == CHAR_T) begin
      tok.kind = TK_LETTER_T;
    end else if (rx_byte == CHAR_F) begin
      tok.kind = TK_LETTER_F;
    end else begin
      tok.kind = TK_OTHER;
    end
  end

endmodule

// ===== src/mclp_queue.sv =====
// short token queue between the front end and the parser
`timescale 1ns / 1ps

module mclp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mclp_pkg::token_t din,
  output logic             full,
  input  logic             pop,
  output mclp_pkg::token_t dout,
  output logic             valid
);
  import mclp_pkg::*;

  token_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  assign full  = (count == CNT_FULL);
  assign valid = (count != '0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mclp_back.sv =====
// back end: line parser, field accumulator and result register
`timescale 1ns / 1ps

module mclp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  mclp_pkg::token_t   tok,
  output logic               q_pop,
  output logic               cmd_valid,
  input  logic               cmd_stall,
  output logic               accepted,
  output logic [2:0]         error_code,
  output logic               motor_id,
  output logic [1:0]         command_kind,
  output logic signed [31:0] target_value,
  output logic signed [31:0] speed_value,
  output logic signed [31:0] accel_value
);
  import mclp_pkg::*;

  stage_t      stage, stage_next;
  logic        motor_sel, motor_sel_next;
  cmd_kind_t   kind_reg, kind_reg_next;
  err_code_t   error_reg, error_reg_next;
  logic [1:0]  field_index, field_index_next;
  logic [3:0]  char_count, char_count_next;
  logic        negative_flag, negative_flag_next;
  logic [31:0] magnitude, magnitude_next;
  logic [31:0] field_store [3];
  logic [31:0] field_store_next [3];
  logic [31:0] store_fin [3];

  logic        take, is_nl, sign_tok, digit_tok, field_done, field_last;
  logic        is_cmd_letter, is_motor;
  logic [3:0]  count_inc;
  logic [2:0]  index_inc, field_total;
  logic [35:0] prod;
  logic [31:0] mag_acc, fin_mag, neg_mag, fin_value;
  logic        fin_neg;
  logic        res_load;
  err_code_t   res_err;

  // a newline only goes through when the result register can take it
  assign is_nl = (tok.kind == TK_NEWLINE);
  assign take  = q_valid && (!is_nl || !cmd_valid || !cmd_stall);
  assign q_pop = take;
  assign res_load = take && is_nl;

  assign sign_tok  = (tok.kind == TK_PLUS || tok.kind == TK_MINUS) && (char_count == 4'd0);
  assign digit_tok = (tok.kind == TK_DIGIT);
  assign count_inc = char_count + 4'd1;
  assign is_cmd_letter = (tok.kind == TK_LETTER_A) || (tok.kind == TK_LETTER_R) ||
                         (tok.kind == TK_LETTER_T);
  assign is_motor = digit_tok && (tok.digit == DIGIT_MOTOR_ONE || tok.digit == DIGIT_MOTOR_TWO);

  // times ten as shift and add, saturating at all ones
  assign prod    = ({4'd0, magnitude} << 3) + ({4'd0, magnitude} << 1) + {32'd0, tok.digit};
  assign mag_acc = (prod[35:32] != 4'd0) ? '1 : prod[31:0];

  // value of the field as it stands after this word
  assign fin_neg   = (sign_tok && !is_nl) ? (tok.kind == TK_MINUS) : negative_flag;
  assign fin_mag   = (digit_tok && !is_nl) ? mag_acc : magnitude;
  assign neg_mag   = (fin_mag > NEG_LIMIT) ? NEG_LIMIT : fin_mag;
  assign fin_value = fin_neg ? (32'd0 - neg_mag) : (fin_mag[31] ? POS_LIMIT : fin_mag);

  assign field_done = (stage == STAGE_FIELDS) &&
                      (is_nl || !(sign_tok || digit_tok) || (count_inc >= FIELD_CHARS));
  assign field_total = (kind_reg == KIND_VEL) ? 3'd2 : 3'd3;
  assign index_inc   = {1'b0, field_index} + 3'd1;
  assign field_last  = (index_inc >= field_total);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      store_fin[i] = (field_done && field_index == 2'(i)) ? fin_value : field_store[i];
    end
  end

  // next stage
  always_comb begin
    stage_next = stage;
    if (take) begin
      if (is_nl) begin
        stage_next = STAGE_MOTOR;
      end else begin
        case (stage)
          STAGE_MOTOR: begin
            stage_next = is_motor ? STAGE_CMD : STAGE_IGNORE;
          end
          STAGE_CMD: begin
            stage_next = is_cmd_letter ? STAGE_FIELDS : STAGE_IGNORE;
          end
          STAGE_FIELDS: begin
            if (field_done && field_last) begin
              stage_next = STAGE_IGNORE;
            end
          end
          default: begin
            stage_next = stage;
          end
        endcase
      end
    end
  end

  // line registers
  always_comb begin
    motor_sel_next     = motor_sel;
    kind_reg_next      = kind_reg;
    error_reg_next     = error_reg;
    field_index_next   = field_index;
    char_count_next    = char_count;
    negative_flag_next = negative_flag;
    magnitude_next     = magnitude;
    for (int i = 0; i < 3; i++) begin
      field_store_next[i] = field_store[i];
    end
    if (take) begin
      if (is_nl) begin
        motor_sel_next     = 1'b0;
        kind_reg_next      = KIND_ABS;
        error_reg_next     = ERR_NONE;
        field_index_next   = 2'd0;
        char_count_next    = 4'd0;
        negative_flag_next = 1'b0;
        magnitude_next     = 32'd0;
        for (int i = 0; i < 3; i++) begin
          field_store_next[i] = 32'd0;
        end
      end else begin
        case (stage)
          STAGE_MOTOR: begin
            if (is_motor) begin
              motor_sel_next = (tok.digit == DIGIT_MOTOR_TWO);
            end else begin
              error_reg_next = ERR_BAD_MOTOR;
            end
          end
          STAGE_CMD: begin
            if (is_cmd_letter) begin
              case (tok.kind)
                TK_LETTER_A: kind_reg_next = KIND_ABS;
                TK_LETTER_R: kind_reg_next = KIND_REL;
                default:     kind_reg_next = KIND_VEL;
              endcase
              field_index_next   = 2'd0;
              char_count_next    = 4'd0;
              negative_flag_next = 1'b0;
              magnitude_next     = 32'd0;
            end else begin
              error_reg_next = (tok.kind == TK_LETTER_F) ? ERR_FEEDBACK : ERR_UNKNOWN;
            end
          end
          STAGE_FIELDS: begin
            if (field_done) begin
              for (int i = 0; i < 3; i++) begin
                field_store_next[i] = store_fin[i];
              end
              char_count_next    = 4'd0;
              negative_flag_next = 1'b0;
              magnitude_next     = 32'd0;
              field_index_next   = index_inc[1:0];
            end else begin
              char_count_next    = count_inc;
              negative_flag_next = fin_neg;
              magnitude_next     = fin_mag;
            end
          end
          default: begin
            motor_sel_next = motor_sel;
          end
        endcase
      end
    end
  end

  always_comb begin
    case (stage)
      STAGE_MOTOR:  res_err = ERR_EMPTY;
      STAGE_CMD:    res_err = ERR_NO_CMD;
      STAGE_FIELDS: res_err = ERR_NONE;
      default:      res_err = error_reg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= STAGE_MOTOR;
      motor_sel     <= 1'b0;
      kind_reg      <= KIND_ABS;
      error_reg     <= ERR_NONE;
      field_index   <= 2'd0;
      char_count    <= 4'd0;
      negative_flag <= 1'b0;
      magnitude     <= 32'd0;
      for (int i = 0; i < 3; i++) begin
        field_store[i] <= 32'd0;
      end
    end else begin
      stage         <= stage_next;
      motor_sel     <= motor_sel_next;
      kind_reg      <= kind_reg_next;
      error_reg     <= error_reg_next;
      field_index   <= field_index_next;
      char_count    <= char_count_next;
      negative_flag <= negative_flag_next;
      magnitude     <= magnitude_next;
      for (int i = 0; i < 3; i++) begin
        field_store[i] <= field_store_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (res_load) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      error_code <= res_err;
      if (res_err == ERR_NONE) begin
        accepted     <= 1'b1;
        motor_id     <= motor_sel;
        command_kind <= kind_reg;
        if (kind_reg == KIND_VEL) begin
          target_value <= 32'sd0;
          speed_value  <= $signed(store_fin[0]);
          accel_value  <= $signed(store_fin[1]);
        end else begin
          target_value <= $signed(store_fin[0]);
          speed_value  <= $signed(store_fin[1]);
          accel_value  <= $signed(store_fin[2]);
        end
      end else begin
        accepted     <= 1'b0;
        motor_id     <= 1'b0;
        command_kind <= KIND_ABS;
        target_value <= 32'sd0;
        speed_value  <= 32'sd0;
        accel_value  <= 32'sd0;
      end
    end
  end

endmodule

// ===== src/mclp_checker.sv =====
// port checks for the motor command line parser, bound to the top level
`timescale 1ns / 1ps
`include "motor_command_line_parser_assert.svh"

module mclp_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input logic               accepted,
  input logic [2:0]         error_code,
  input logic               motor_id,
  input logic [1:0]         command_kind,
  input logic signed [31:0] target_value,
  input logic signed [31:0] speed_value,
  input logic signed [31:0] accel_value
);
  import mclp_pkg::*;

  // a held result keeps its word
  `MCLP_ASSERT_NEXT(a_hold, cmd_valid && cmd_stall, cmd_valid && $stable(error_code) && $stable(accepted) && $stable(target_value) && $stable(speed_value) && $stable(accel_value), "stalled result changed")
  // accepted flag agrees with the error code
  `MCLP_ASSERT_NOW(a_acc_err, cmd_valid, accepted == (error_code == ERR_NONE), "accepted and error code disagree")
  // a rejected line carries nothing but its error code
  `MCLP_ASSERT_NOW(a_rej_zero, cmd_valid && !accepted, motor_id == 1'b0 && command_kind == KIND_ABS && target_value == 32'sd0 && speed_value == 32'sd0 && accel_value == 32'sd0, "rejected line has payload")
  // velocity moves have no target
  `MCLP_ASSERT_NOW(a_vel_target, cmd_valid && accepted && command_kind == KIND_VEL, target_value == 32'sd0, "velocity move with target")

endmodule

bind motor_command_line_parser mclp_checker u_checker (.*);

// ===== test/motor_command_line_parser_test.sv =====
// self-checking testbench for the motor command line parser
`timescale 1ns / 1ps

module motor_command_line_parser_test;
  import mclp_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 9;
  localparam int BYTES_PER_PHASE = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_COMMA     = 8'h2c;
  localparam logic [7:0] CHAR_MOTOR_ONE = CHAR_ZERO + {4'd0, DIGIT_MOTOR_ONE};
  localparam logic [7:0] CHAR_MOTOR_TWO = CHAR_ZERO + {4'd0, DIGIT_MOTOR_TWO};

  typedef struct {
    logic        ok;
    logic [2:0]  code;
    logic        motor;
    logic [1:0]  kind;
    logic [31:0] target;
    logic [31:0] speed;
    logic [31:0] accel;
  } command_t;

  class command_scoreboard;
    stage_t      stage;
    logic        sel_motor;
    cmd_kind_t   cur_kind;
    err_code_t   line_err;
    int unsigned field_idx;
    int unsigned char_cnt;
    logic        is_neg;
    logic [31:0] mag;
    logic [31:0] field_val [3];
    command_t    pending_cmds [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      stage     = STAGE_MOTOR;
      sel_motor = 1'b0;
      cur_kind  = KIND_ABS;
      line_err  = ERR_NONE;
      field_idx = 0;
      char_cnt  = 0;
      is_neg    = 1'b0;
      mag       = '0;
      foreach (field_val[i]) field_val[i] = '0;
    endfunction

    // clamp the magnitude into the signed range and move to the next field
    function void end_field();
      logic [31:0] v;
      if (is_neg) begin
        v = 32'd0 - ((mag > NEG_LIMIT) ? NEG_LIMIT : mag);
      end else begin
        v = (mag > POS_LIMIT) ? POS_LIMIT : mag;
      end
      if (field_idx < 3) field_val[field_idx] = v;
      char_cnt = 0;
      is_neg   = 1'b0;
      mag      = '0;
      field_idx++;
      if (field_idx >= ((cur_kind == KIND_VEL) ? 2 : 3)) stage = STAGE_IGNORE;
    endfunction

    function void take_byte(logic [7:0] b);
      command_t    c;
      logic [35:0] t;
      if (b == CHAR_NEWLINE) begin
        c.ok = 1'b0; c.motor = 1'b0; c.kind = KIND_ABS;
        c.target = '0; c.speed = '0; c.accel = '0;
        case (stage)
          STAGE_MOTOR: c.code = ERR_EMPTY;
          STAGE_CMD:   c.code = ERR_NO_CMD;
          STAGE_FIELDS: begin
            end_field();
            c.code = ERR_NONE;
          end
          default:     c.code = line_err;
        endcase
        if (c.code == ERR_NONE) begin
          c.ok    = 1'b1;
          c.motor = sel_motor;
          c.kind  = cur_kind;
          if (cur_kind == KIND_VEL) begin
            c.speed = field_val[0];
            c.accel = field_val[1];
          end else begin
            c.target = field_val[0];
            c.speed  = field_val[1];
            c.accel  = field_val[2];
          end
        end
        pending_cmds = {pending_cmds, c};
        clear_line();
        return;
      end
      case (stage)
        STAGE_MOTOR: begin
          if (b == CHAR_MOTOR_ONE || b == CHAR_MOTOR_TWO) begin
            sel_motor = (b == CHAR_MOTOR_TWO);
            stage     = STAGE_CMD;
          end else begin
            line_err = ERR_BAD_MOTOR;
            stage    = STAGE_IGNORE;
          end
        end
        STAGE_CMD: begin
          if (b == CHAR_A || b == CHAR_R || b == CHAR_T) begin
            cur_kind  = (b == CHAR_A) ? KIND_ABS : (b == CHAR_R) ? KIND_REL : KIND_VEL;
            field_idx = 0;
            char_cnt  = 0;
            is_neg    = 1'b0;
            mag       = '0;
            stage     = STAGE_FIELDS;
          end else begin
            line_err = (b == CHAR_F) ? ERR_FEEDBACK : ERR_UNKNOWN;
            stage    = STAGE_IGNORE;
          end
        end
        STAGE_FIELDS: begin
          // a sign only counts as the first character of a field
          if ((b == CHAR_MINUS || b == CHAR_PLUS) && char_cnt == 0) begin
            is_neg = (b == CHAR_MINUS);
            char_cnt++;
          end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            t   = {4'd0, mag} * 36'd10 + {28'd0, b - CHAR_ZERO};
            mag = (t > 36'hffff_ffff) ? 32'hffff_ffff : t[31:0];
            char_cnt++;
          end else begin
            end_field();
            return;
          end
          if (char_cnt >= FIELD_CHARS) end_field();
        end
        default: ;
      endcase
    endfunction

    function void check_command(logic ok, logic [2:0] code, logic motor, logic [1:0] kind,
                                logic [31:0] target, logic [31:0] speed, logic [31:0] accel);
      command_t want;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected command word: ok=%0d code=%0d motor=%0d kind=%0d",
                   ok, code, motor, kind);
        return;
      end
      want = pending_cmds.pop_front();
      if (ok !== want.ok || code !== want.code || motor !== want.motor ||
          kind !== want.kind || target !== want.target || speed !== want.speed ||
          accel !== want.accel) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("command mismatch: expected ok=%0d code=%0d motor=%0d kind=%0d %0d %0d %0d",
                   want.ok, want.code, want.motor, want.kind, $signed(want.target),
                   $signed(want.speed), $signed(want.accel));
          $display("                  actual   ok=%0d code=%0d motor=%0d kind=%0d %0d %0d %0d",
                   ok, code, motor, kind, $signed(target), $signed(speed), $signed(accel));
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               rx_valid;
  logic               rx_stall;
  logic [7:0]         rx_byte;
  logic               cmd_valid;
  logic               cmd_stall;
  logic               accepted;
  logic [2:0]         error_code;
  logic               motor_id;
  logic [1:0]         command_kind;
  logic signed [31:0] target_value;
  logic signed [31:0] speed_value;
  logic signed [31:0] accel_value;

  command_scoreboard sb;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles     = 0;
  int unsigned idle_by_phase  [4] = '{0, 74, 0, 8};
  int unsigned stall_by_phase [4] = '{0, 0, 74, 8};

  motor_command_line_parser dut (.*);

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall)
      sb.check_command(accepted, error_code, motor_id, command_kind,
                       target_value, speed_value, accel_value);
    cmd_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_NEWLINE);
    return b;
  endfunction

  // offer one word, holding it until the parser takes it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      rx_valid <= 1'b0;
      rx_byte  <= 8'($urandom_range(255));
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_random_line();
    int unsigned shape;
    int unsigned nfields;
    int unsigned ndig;
    int unsigned sign;
    logic        nines;
    shape = $urandom_range(99);
    if (shape < 75) begin
      send_byte($urandom_range(1) ? CHAR_MOTOR_TWO : CHAR_MOTOR_ONE);
      case ($urandom_range(2))
        0: send_byte(CHAR_A);
        1: send_byte(CHAR_R);
        default: send_byte(CHAR_T);
      endcase
      nfields = $urandom_range(4);
      for (int i = 0; i < nfields; i++) begin
        sign = $urandom_range(3);
        if (sign == 1) send_byte(CHAR_MINUS);
        if (sign == 2) send_byte(CHAR_PLUS);
        ndig  = ($urandom_range(4) == 0) ? $urandom_range(16, 10) : $urandom_range(9);
        nines = ($urandom_range(9) == 0);
        for (int j = 0; j < ndig; j++)
          send_byte(nines ? CHAR_NINE : 8'(CHAR_ZERO + $urandom_range(9)));
        if (i + 1 < nfields || $urandom_range(1)) begin
          case ($urandom_range(3))
            0: send_byte(CHAR_SPACE);
            1: send_byte(CHAR_COMMA);
            default: send_byte(noise_byte());
          endcase
        end
      end
      repeat ($urandom_range(3)) send_byte(noise_byte());
    end else if (shape < 80) begin
      // empty line, nothing before the newline
    end else if (shape < 88) begin
      send_byte(noise_byte());
      repeat ($urandom_range(6)) send_byte(noise_byte());
    end else if (shape < 95) begin
      send_byte($urandom_range(1) ? CHAR_MOTOR_TWO : CHAR_MOTOR_ONE);
      send_byte($urandom_range(1) ? CHAR_F : noise_byte());
      repeat ($urandom_range(6)) send_byte(noise_byte());
    end else begin
      send_byte($urandom_range(1) ? CHAR_MOTOR_TWO : CHAR_MOTOR_ONE);
    end
    send_byte(CHAR_NEWLINE);
  endtask

  initial begin
    int unsigned target_bytes;
    sb = new();
    rst       <= 1'b1;
    rx_valid  <= 1'b0;
    rx_byte   <= 8'd0;
    cmd_stall <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // error lines: empty, bad motor at both byte extremes, no command, feedback, unknown
    send_text("\n");
    send_byte(8'hff);
    send_byte(CHAR_NEWLINE);
    send_byte(8'h00);
    send_byte(CHAR_NEWLINE);
    send_text("1\n");
    send_text("2F\n");
    send_text("1Q\n");
    // missing fields, signs, full range, saturation, length limit
    send_text("1A\n");
    send_text("2R-5,+7 9\n");
    send_text("1T+2147483647 -2147483648 55\n");
    send_text("2A99999999999,-99999999999\n");
    send_text("1R123456789012345678\n");
    // second sign ends a field, bare signs read as zero, trailing junk ignored
    send_text("2A5-3+-4\n");
    send_text("1A-,+\n");
    send_text("2T1,2,3xyz\n");
    send_text("1A7\n");

    for (int p = 0; p < 4; p++) begin
      idle_pct     = idle_by_phase[p];
      stall_pct    = stall_by_phase[p];
      target_bytes = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target_bytes) send_random_line();
    end

    rx_valid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mclp_pkg.sv
src/mclp_front.sv
src/mclp_queue.sv
src/mclp_back.sv
src/motor_command_line_parser.sv
src/mclp_checker.sv
test/motor_command_line_parser_test.sv
